// ===== rtl/gqd_pkg.sv =====
// Shared types and constants for the gray quantizer with dither.
`default_nettype none

package gqd_pkg;

  localparam int GRAY_LEVELS = 256;
  localparam int GRAY_BITS   = 8;
  localparam int NOISE_BITS  = 4;   // dither amplitude mask 0xf
  localparam int DIV_BITS    = 9;   // width of 2*steps and of the divider

  localparam logic [GRAY_BITS-1:0] MAX_GRAY        = 8'hFF;
  localparam logic [8:0]           LEVEL_COUNT_RST = 9'd256;
  localparam logic [15:0]          NOISE_SEED_RST  = 16'hACE1;
  localparam logic [8:0]           TWO_MAX_GRAY    = 9'd510;

  // configuration register indexes
  localparam logic [1:0] CFG_LEVEL_COUNT   = 2'd0;
  localparam logic [1:0] CFG_DITHER_ENABLE = 2'd1;
  localparam logic [1:0] CFG_NOISE_SEED    = 2'd2;

  typedef enum logic [1:0] {
    FILL_LOAD,
    FILL_DIV,
    FILL_SWEEP,
    FILL_DONE
  } fill_state_t;

  typedef struct packed {
    logic                 we;
    logic [GRAY_BITS-1:0] addr;
    logic [GRAY_BITS-1:0] data;
  } gqd_wr_t;

endpackage

`default_nettype wire

// ===== rtl/gqd_fill.sv =====
// Level table fill engine: one divide for the step size, then a 256-entry sweep.
`default_nettype none

module gqd_fill import gqd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [8:0] level_count,
  output logic       busy,
  output gqd_wr_t    wr
);

  fill_state_t state_r, state_nxt;

  logic [DIV_BITS-1:0] d_r;        // 2*steps
  logic [DIV_BITS-1:0] dvd_r;      // 510, shifted out MSB first
  logic [DIV_BITS-1:0] div_rem_r;  // ends as 510 mod 2*steps
  logic [DIV_BITS-1:0] k_r;        // ends as 510 / 2*steps
  logic [3:0]          cnt_r;
  logic [8:0]          qrem_r;     // remainder of first rounding, < 510
  logic [8:0]          rrem_r;     // remainder of second rounding, < 2*steps
  logic [9:0]          r_r;        // current table value
  logic [7:0]          v_r;        // table address

  logic [7:0]  steps;
  logic [9:0]  trial;
  logic        ge;
  logic [8:0]  div_rem_nxt;
  logic [9:0]  qsum;
  logic        qcarry;
  logic [8:0]  qrem_nxt;
  logic [9:0]  rsum;
  logic        rcarry;
  logic [8:0]  rrem_nxt;
  logic [9:0]  r_nxt;

  // level count clamped to 2..256, steps = levels - 1
  always_comb begin
    priority if (level_count < 9'd2) begin
      steps = 8'd1;
    end else if (level_count > 9'd256) begin
      steps = 8'd255;
    end else begin
      steps = 8'(level_count - 9'd1);
    end
  end

  // restoring divide step
  assign trial       = {div_rem_r, dvd_r[DIV_BITS-1]};
  assign ge          = trial >= {1'b0, d_r};
  assign div_rem_nxt = ge ? 9'(trial - {1'b0, d_r}) : trial[8:0];

  // incremental rounding: q steps up when the first remainder wraps,
  // and each q step moves r by k plus a carry
  assign qsum     = {1'b0, qrem_r} + {1'b0, d_r};
  assign qcarry   = qsum >= {1'b0, TWO_MAX_GRAY};
  assign qrem_nxt = qcarry ? 9'(qsum - {1'b0, TWO_MAX_GRAY}) : qsum[8:0];
  assign rsum     = {1'b0, rrem_r} + {1'b0, div_rem_r};
  assign rcarry   = rsum >= {1'b0, d_r};
  assign rrem_nxt = rcarry ? 9'(rsum - {1'b0, d_r}) : rsum[8:0];
  assign r_nxt    = r_r + {1'b0, k_r} + {9'd0, rcarry};

  always_comb begin
    state_nxt = state_r;
    priority if (start) begin
      state_nxt = FILL_LOAD;
    end else begin
      unique case (state_r)
        FILL_LOAD:  state_nxt = FILL_DIV;
        FILL_DIV:   if (cnt_r == 4'(DIV_BITS - 1)) state_nxt = FILL_SWEEP;
        FILL_SWEEP: if (v_r == MAX_GRAY) state_nxt = FILL_DONE;
        FILL_DONE:  state_nxt = FILL_DONE;
      endcase
    end
  end

  always_comb begin
    busy    = 1'b1;
    wr.we   = 1'b0;
    wr.addr = v_r;
    wr.data = (r_r[9:8] != 2'd0) ? MAX_GRAY : r_r[7:0];
    unique case (state_r)
      FILL_LOAD:  busy  = 1'b1;
      FILL_DIV:   busy  = 1'b1;
      FILL_SWEEP: wr.we = 1'b1;
      FILL_DONE:  busy  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FILL_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      FILL_LOAD: begin
        d_r       <= {steps, 1'b0};
        dvd_r     <= TWO_MAX_GRAY;
        div_rem_r <= '0;
        k_r       <= '0;
        cnt_r     <= '0;
        qrem_r    <= 9'd255;
        rrem_r    <= {1'b0, steps};
        r_r       <= '0;
        v_r       <= '0;
      end
      FILL_DIV: begin
        div_rem_r <= div_rem_nxt;
        k_r       <= {k_r[DIV_BITS-2:0], ge};
        dvd_r     <= {dvd_r[DIV_BITS-2:0], 1'b0};
        cnt_r     <= cnt_r + 4'd1;
      end
      FILL_SWEEP: begin
        qrem_r <= qrem_nxt;
        v_r    <= v_r + 8'd1;
        if (qcarry) begin
          rrem_r <= rrem_nxt;
          r_r    <= r_nxt;
        end
      end
      FILL_DONE: begin
        v_r <= v_r;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/gray_quantizer_with_dither.sv =====
// Top level: gray-level quantizer with checkerboard dither and table lookup.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_stall in_pixel_in             | pixel in
//          | in_frame_start in_row_end                 |
//  out     | out_valid out_stall out_pixel_out         | pixel out
//  cfg     | cfg_we cfg_index cfg_data                 | reg write
//
//  One pixel per cycle while in_stall is low; stages: table read, output reg.
//  After reset and after each level_count write the table is rebuilt by
//  one load, 9 divide steps and 256 writes; in_stall is high then.
//  The read stage and the output register form a two-deep pipe, so a
//  stalled output blocks input only once both hold a pixel.
//  Reset is synchronous; a write to noise_seed also reloads the noise LFSR.
`default_nettype none

module gray_quantizer_with_dither import gqd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_in,
  input  logic        in_frame_start,
  input  logic        in_row_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [8:0]  level_count_r;
  logic        dither_en_r;
  logic [15:0] noise_r;
  logic        col_r, row_r;
  logic        s1_v_r;            // table read data valid
  logic        out_v_r;
  logic [7:0]  rd_q_r;
  logic [7:0]  out_pix_r;

  logic [7:0]  level_mem [GRAY_LEVELS];

  logic        fill_busy;
  gqd_wr_t     fill_wr;
  logic        fill_start;

  logic        accept;
  logic        s1_move;
  logic        col, row;
  logic        col_nxt, row_nxt;
  logic [3:0]  delta;
  logic [8:0]  up_sum;
  logic [7:0]  up_idx, dn_idx, rd_idx;
  logic        fb;
  logic [15:0] noise_nxt;

  assign fill_start = cfg_we && (cfg_index == CFG_LEVEL_COUNT);

  gqd_fill u_fill (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (fill_start),
    .level_count (level_count_r),
    .busy        (fill_busy),
    .wr          (fill_wr)
  );

  // handshake: read stage may advance into the output register when it is
  // empty or being drained this cycle
  assign s1_move  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = fill_busy || (s1_v_r && !s1_move);
  assign accept   = in_valid && !in_stall;

  // frame start puts this pixel at row 0, column 0
  assign col = in_frame_start ? 1'b0 : col_r;
  assign row = in_frame_start ? 1'b0 : row_r;

  // dither: add noise on odd checkerboard squares, subtract on even, clip
  assign delta  = noise_r[NOISE_BITS-1:0];
  assign up_sum = {1'b0, in_pixel_in} + {5'd0, delta};
  assign up_idx = up_sum[8] ? MAX_GRAY : up_sum[7:0];
  assign dn_idx = (in_pixel_in >= {4'd0, delta}) ? 8'(in_pixel_in - {4'd0, delta}) : 8'd0;

  always_comb begin
    priority if (!dither_en_r) begin
      rd_idx = in_pixel_in;
    end else if (row != col) begin
      rd_idx = up_idx;
    end else begin
      rd_idx = dn_idx;
    end
  end

  // LFSR taps 16,14,13,11, shifting right
  assign fb        = noise_r[0] ^ noise_r[2] ^ noise_r[3] ^ noise_r[5];
  assign noise_nxt = {fb, noise_r[15:1]};

  always_comb begin
    if (in_row_end) begin
      col_nxt = 1'b0;
      row_nxt = !row;
    end else begin
      col_nxt = !col;
      row_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= LEVEL_COUNT_RST;
      dither_en_r   <= 1'b0;
      noise_r       <= NOISE_SEED_RST;
      col_r         <= 1'b0;
      row_r         <= 1'b0;
      s1_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_LEVEL_COUNT) begin
        level_count_r <= cfg_data[8:0];
      end
      if (cfg_we && cfg_index == CFG_DITHER_ENABLE) begin
        dither_en_r <= cfg_data[0];
      end
      // noise advances only on dithered pixels
      if (cfg_we && cfg_index == CFG_NOISE_SEED) begin
        noise_r <= cfg_data;
      end else if (accept && dither_en_r) begin
        noise_r <= noise_nxt;
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_v_r  <= accept || (s1_v_r && !s1_move);
      out_v_r <= s1_move || (out_v_r && out_stall);
    end
  end

  // level table: fill engine writes, pixel path reads
  always_ff @(posedge clk) begin
    if (fill_wr.we) begin
      level_mem[fill_wr.addr] <= fill_wr.data;
    end
    if (accept) begin
      rd_q_r <= level_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pix_r <= rd_q_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_pixel_out = out_pix_r;

endmodule

`default_nettype wire

// ===== rtl/gqd_chk.sv =====
// Port-level checks for the gray quantizer, bound to the top level.
`default_nettype none

module gqd_chk import gqd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_pixel_out,
  input logic        cfg_we,
  input logic [1:0]  cfg_index
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pixel_out)))
    else $error("stalled output changed");

  // a new level count rebuilds the table, so input is held off
  a_fill_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_LEVEL_COUNT) |=> in_stall)
    else $error("pixel accepted during table rebuild");

  // with the output free, a transfer shows up after the read stage and the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |-> ##2 out_valid)
    else $error("result missing after accepted pixel");

  // no result without an earlier input transfer through the read stage
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without accepted pixel");

endmodule

bind gray_quantizer_with_dither gqd_chk u_gqd_chk (.*);

`default_nettype wire

// ===== bench/tb_gray_quantizer_with_dither.sv =====
// Self-checking bench for gray_quantizer_with_dither: directed, random raster frames.
`default_nettype none

module tb_gray_quantizer_with_dither;
  import gqd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 3000;  // outlasts a table rebuild plus the receiver hold-off
  localparam int HOLD_CYCLES  = 80;    // receiver back-pressure stretch
  localparam int TAIL_CYCLES  = 8;     // two-stage pipe, plus margin for strays
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int IDLE_PERCENT = 21;

  // index 3 decodes to no register; writes there must be harmless
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Tracks the quantizer state (table, LFSR, checkerboard position) and holds
  // the pixel values still owed on the output channel, oldest first.
  class quantized_pixel_tracker;
    logic [7:0]  level_lut [GRAY_LEVELS];
    logic [8:0]  levels;
    logic        dither_on;
    logic [15:0] lfsr;
    logic        col_odd;
    logic        row_odd;
    logic [7:0]  pixels_due [$];
    int          errors;
    int          shown;

    function new();
      levels    = LEVEL_COUNT_RST;
      dither_on = 1'b0;
      lfsr      = NOISE_SEED_RST;
      col_odd   = 1'b0;
      row_odd   = 1'b0;
      errors    = 0;
      shown     = 0;
      build_lut();
    endfunction

    // round-half-up to the level index, then back to a gray value
    function void build_lut();
      int unsigned n;
      int unsigned steps;
      int unsigned q;
      int unsigned r;
      n = levels;
      if (n < 2) n = 2;
      if (n > 256) n = 256;
      steps = n - 1;
      for (int v = 0; v < GRAY_LEVELS; v++) begin
        q = (2 * v * steps + 255) / 510;
        r = (2 * q * 255 + steps) / (2 * steps);
        if (r > 255) r = 255;
        level_lut[v] = r[7:0];
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_LEVEL_COUNT: begin
          levels = data[8:0];
          build_lut();
        end
        CFG_DITHER_ENABLE: dither_on = data[0];
        CFG_NOISE_SEED:    lfsr = data;
        default: ;
      endcase
    endfunction

    // one accepted input transfer -> one expected output pixel
    function void take_pixel(logic [7:0] pix, logic fs, logic re);
      int         idx;
      logic [3:0] delta;
      idx = pix;
      if (fs) begin
        col_odd = 1'b0;
        row_odd = 1'b0;
      end
      if (dither_on) begin
        delta = lfsr[3:0];  // taken before the shift
        lfsr  = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
        if (row_odd != col_odd) begin
          idx = int'(pix) + int'(delta);
          if (idx > 255) idx = 255;
        end else begin
          idx = int'(pix) - int'(delta);
          if (idx < 0) idx = 0;
        end
      end
      pixels_due.push_back(level_lut[idx]);
      if (re) begin
        col_odd = 1'b0;
        row_odd = ~row_odd;
      end else begin
        col_odd = ~col_odd;
      end
    endfunction

    function void note_error(string msg);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function void match_pixel(logic [7:0] got);
      logic [7:0] want;
      if (pixels_due.size() == 0) begin
        note_error($sformatf("pixel_out %0d with nothing outstanding", got));
        return;
      end
      want = pixels_due.pop_front();
      if (got !== want)
        note_error($sformatf("pixel_out mismatch: expected %0d, got %0d", want, got));
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_pixel_in    = 8'd0;
  logic        in_frame_start = 1'b0;
  logic        in_row_end     = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [7:0]  out_pixel_out;
  logic        cfg_we         = 1'b0;
  logic [1:0]  cfg_index      = 2'd0;
  logic [15:0] cfg_data       = 16'd0;

  quantized_pixel_tracker book = new();

  // idle controls and the hold-off request; the main sequence writes them
  // only at rising edges, the receiver reads them at falling edges
  logic src_idle_on  = 1'b1;
  logic sink_idle_on = 1'b1;
  int   hold_reqs    = 0;
  int   hold_served  = 0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;

  int level_picks [PHASES] = '{0, 1, 2, 3, 4, 7, 16, 100, 255, 256, 257, 511};

  gray_quantizer_with_dither uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_in    (in_pixel_in),
    .in_frame_start (in_frame_start),
    .in_row_end     (in_row_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or a long counted hold-off on request. The
  // hold-off starts with the first result after the request, so it lands
  // after the table rebuild; the sender keeps offering, the two-deep pipe
  // fills and in_stall has to rise.
  always @(negedge clk) begin
    if (hold_served != hold_reqs && out_valid) begin
      hold_served = hold_reqs;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= sink_idle_on && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Monitor: everything is sampled at the rising edge, before the block's
  // registers move. The output is checked before the same-edge input is
  // noted, so a result can never be matched to its own input transfer.
  always @(posedge clk) begin : monitor
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        book.match_pixel(out_pixel_out);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        book.take_pixel(in_pixel_in, in_frame_start, in_row_end);
        moved = 1'b1;
      end
      if (cfg_we) begin
        book.set_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_gray_quantizer_with_dither: done, errors");
        $finish;
      end
    end
  end

  // biased toward the ends of the gray range so dither clipping is hit
  function automatic logic [7:0] pick_pixel();
    int k;
    k = $urandom_range(99);
    if (k < 12) return 8'd0;
    if (k < 24) return MAX_GRAY;
    if (k < 34) return 8'($urandom_range(15));
    if (k < 44) return 8'($urandom_range(255, 240));
    return 8'($urandom_range(255));
  endfunction

  // offer one pixel, holding the payload until the transfer happens
  task automatic send_pixel(input logic [7:0] pix, input logic fs, input logic re);
    @(negedge clk);
    while (src_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_in    <= pix;
    in_frame_start <= fs;
    in_row_end     <= re;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // every pixel yields exactly one result, so an empty queue means idle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Mostly well-formed raster frames of random size; a few markers are
  // flipped so that frames start mid-count and rows end early or run on.
  task automatic send_frames(input int total);
    int   left;
    int   width;
    int   rows;
    logic fs;
    logic re;
    left = total;
    while (left > 0) begin
      width = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(40, 13);
      rows  = $urandom_range(6, 1);
      for (int r = 0; r < rows && left > 0; r++) begin
        for (int c = 0; c < width && left > 0; c++) begin
          fs = (r == 0 && c == 0);
          re = (c == width - 1);
          if ($urandom_range(99) < 6) fs = ~fs;
          if ($urandom_range(99) < 6) re = ~re;
          send_pixel(pick_pixel(), fs, re);
          left--;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] word;
    logic [15:0] seed_picks [4];
    seed_picks[0] = 16'h0001;
    seed_picks[1] = 16'hFFFF;
    seed_picks[2] = 16'h0000;
    seed_picks[3] = 16'($urandom_range(65535, 1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: 256 levels (identity), dither off
    send_pixel(8'd0,   1'b1, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b1);
    send_pixel(8'd127, 1'b0, 1'b0);
    drain_results();

    // two levels with dither: subtract clips at 0, add clips at 255, both
    // parities on two rows, then a frame start right after a row end
    write_reg(CFG_LEVEL_COUNT, 16'd2);
    write_reg(CFG_DITHER_ENABLE, 16'd1);
    send_pixel(8'd0,   1'b1, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd5,   1'b0, 1'b0);
    send_pixel(8'd250, 1'b0, 1'b1);
    send_pixel(8'd0,   1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd127, 1'b0, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b1);
    send_pixel(8'd130, 1'b1, 1'b0);
    send_pixel(8'd126, 1'b0, 1'b1);
    drain_results();

    // zero seed: the LFSR is stuck, noise is always zero
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(CFG_NOISE_SEED, 16'h0000);
    write_reg(CFG_LEVEL_COUNT, 16'd3);
    send_pixel(8'd3,   1'b1, 1'b0);
    send_pixel(8'd252, 1'b0, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b1);
    send_pixel(8'd127, 1'b0, 1'b0);
    drain_results();

    // all-ones seed, identity table, dither near the clip points
    write_reg(CFG_NOISE_SEED, 16'hFFFF);
    write_reg(CFG_LEVEL_COUNT, 16'd256);
    send_pixel(8'd8,   1'b1, 1'b0);
    send_pixel(8'd247, 1'b0, 1'b1);
    send_pixel(8'd15,  1'b0, 1'b0);
    send_pixel(8'd240, 1'b0, 1'b1);
    drain_results();

    // random phases: each one a new level count, dither on in most, a new
    // seed in some; odd phases put junk above the decoded register bits
    for (int p = 0; p < PHASES; p++) begin
      src_idle_on  = (p != 1);  // phase 1 runs flat out on both sides
      sink_idle_on = (p != 1);
      if (p == 4) hold_reqs = hold_reqs + 1;
      word = (p % 2) ? 16'($urandom_range(65535)) : 16'd0;
      word[8:0] = 9'(level_picks[p]);
      write_reg(CFG_LEVEL_COUNT, word);
      word = (p % 2) ? 16'($urandom_range(65535)) : 16'd0;
      word[0] = (p % 4 != 2);
      write_reg(CFG_DITHER_ENABLE, word);
      if (p % 3 == 0) write_reg(CFG_NOISE_SEED, seed_picks[p / 3]);
      send_frames(PHASE_ITEMS);
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb_gray_quantizer_with_dither: done, clean");
    end else begin
      $display("tb_gray_quantizer_with_dither: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
